@@ rtl/kvia_pkg.sv @@
// ---------------------------------------------------------------------------
// kvia_pkg: shared types and codes of the known-value integer ALU
// Opcode names and the control word that travels down the divider row.
// ---------------------------------------------------------------------------
package kvia_pkg;

    typedef enum logic [4:0] {
        OP_LOR  = 5'd0,
        OP_LAND = 5'd1,
        OP_OR   = 5'd2,
        OP_XOR  = 5'd3,
        OP_AND  = 5'd4,
        OP_EQ   = 5'd5,
        OP_NE   = 5'd6,
        OP_LT   = 5'd7,
        OP_GT   = 5'd8,
        OP_GE   = 5'd9,
        OP_LE   = 5'd10,
        OP_SHR  = 5'd11,
        OP_SHL  = 5'd12,
        OP_SUB  = 5'd13,
        OP_ADD  = 5'd14,
        OP_MUL  = 5'd15,
        OP_DIV  = 5'd16,
        OP_MOD  = 5'd17,
        OP_NEG  = 5'd18,
        OP_LNOT = 5'd19,
        OP_NOT  = 5'd20
    } opcode_t;

    // Control that travels with each operation.
    typedef struct packed {
        logic vld;
        logic known;
        logic is_div;
        logic is_mod;
        logic neg_q;
        logic neg_r;
    } ctl_t;

endpackage

@@ rtl/kvia_prep.sv @@
// ---------------------------------------------------------------------------
// kvia_prep: operand decode and two-stage front end
// Computes the simple operations, the multiply in half-width partial
// products, and the divider operand magnitudes.
// ---------------------------------------------------------------------------
module kvia_prep #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [4:0]               opcode,
    input  logic [63:0]              left_value,
    input  logic                     left_known,
    input  logic [63:0]              right_value,
    input  logic                     right_known,
    output kvia_pkg::ctl_t           ctl,
    output logic [DATA_WIDTH-1:0]    res,
    output logic [DATA_WIDTH-1:0]    mag_a,
    output logic [DATA_WIDTH-1:0]    mag_b
);
    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int HH = W - H;
    localparam int SW = $clog2(W);

    logic [W-1:0]    a, b, r;
    logic            known, unary, lt, gt, sh_ok;
    logic [SW-1:0]   shamt;
    kvia_pkg::ctl_t  c;

    kvia_pkg::ctl_t  ctl1_reg;
    logic [W-1:0]    res1_reg, ma1_reg, mb1_reg;
    logic            mul1_reg;
    logic [2*H-1:0]  pll_reg;
    logic [HH-1:0]   plh_reg, phl_reg;
    kvia_pkg::ctl_t  ctl2_reg;
    logic [W-1:0]    res2_reg, ma2_reg, mb2_reg;
    logic [W-1:0]    mul_sum;

    // Operand decode and the simple operations.
    always_comb
    begin
        a      = left_value[W-1:0];
        b      = right_value[W-1:0];
        lt     = $signed(a) < $signed(b);
        gt     = $signed(b) < $signed(a);
        sh_ok  = b < W'(W);
        shamt  = b[SW-1:0];
        unary  = (opcode == kvia_pkg::OP_NEG) || (opcode == kvia_pkg::OP_LNOT)
              || (opcode == kvia_pkg::OP_NOT);
        known  = unary ? left_known : (left_known && right_known);
        r      = '0;
        c      = '0;
        c.vld  = start;
        unique case (opcode)
            kvia_pkg::OP_LOR:  r = W'((a != '0) || (b != '0));
            kvia_pkg::OP_LAND: r = W'((a != '0) && (b != '0));
            kvia_pkg::OP_OR:   r = a | b;
            kvia_pkg::OP_XOR:  r = a ^ b;
            kvia_pkg::OP_AND:  r = a & b;
            kvia_pkg::OP_EQ:   r = W'(a == b);
            kvia_pkg::OP_NE:   r = W'(a != b);
            kvia_pkg::OP_LT:   r = W'(lt);
            kvia_pkg::OP_GT:   r = W'(gt);
            kvia_pkg::OP_GE:   r = W'(!lt);
            kvia_pkg::OP_LE:   r = W'(!gt);
            kvia_pkg::OP_SHR:
            begin
                r     = W'($signed(a) >>> shamt);
                known = known && sh_ok;
            end
            kvia_pkg::OP_SHL:
            begin
                r     = a << shamt;
                known = known && sh_ok;
            end
            kvia_pkg::OP_SUB:  r = a - b;
            kvia_pkg::OP_ADD:  r = a + b;
            kvia_pkg::OP_MUL:  r = '0;
            kvia_pkg::OP_DIV:
            begin
                c.is_div = 1'b1;
                known    = known && (b != '0);
            end
            kvia_pkg::OP_MOD:
            begin
                c.is_mod = 1'b1;
                known    = known && (b != '0);
            end
            kvia_pkg::OP_NEG:  r = '0 - a;
            kvia_pkg::OP_LNOT: r = W'(a == '0);
            kvia_pkg::OP_NOT:  r = ~a;
            default:           known = 1'b0;
        endcase
        c.known = known;
        c.neg_q = a[W-1] ^ b[W-1];
        c.neg_r = a[W-1];
    end

    // Stages one and two: control transfer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= c;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Stage one payload: partial products and divider magnitudes.
    always_ff @(posedge clk)
    begin
        res1_reg <= r;
        mul1_reg <= (opcode == kvia_pkg::OP_MUL);
        ma1_reg  <= a[W-1] ? ('0 - a) : a;
        mb1_reg  <= b[W-1] ? ('0 - b) : b;
        pll_reg  <= a[H-1:0] * b[H-1:0];
        plh_reg  <= HH'(a[H-1:0] * b[W-1:H]);
        phl_reg  <= HH'(a[W-1:H] * b[H-1:0]);
    end

    // Stage two: sum of the partial products, low word only.
    assign mul_sum = W'(pll_reg) + {plh_reg + phl_reg, {H{1'b0}}};

    always_ff @(posedge clk)
    begin
        res2_reg <= mul1_reg ? mul_sum : res1_reg;
        ma2_reg  <= ma1_reg;
        mb2_reg  <= mb1_reg;
    end

    assign ctl   = ctl2_reg;
    assign res   = res2_reg;
    assign mag_a = ma2_reg;
    assign mag_b = mb2_reg;

endmodule

@@ rtl/kvia_cell.sv @@
// ---------------------------------------------------------------------------
// kvia_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits, and hands everything to the next cell.
// ---------------------------------------------------------------------------
module kvia_cell #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kvia_pkg::ctl_t        ctl_in,
    input  logic [DATA_WIDTH-1:0] res_in,
    input  logic [DATA_WIDTH-1:0] dvs_in,
    input  logic [DATA_WIDTH-1:0] dvd_in,
    input  logic [DATA_WIDTH-1:0] rem_in,
    input  logic [DATA_WIDTH-1:0] quo_in,
    output kvia_pkg::ctl_t        ctl_out,
    output logic [DATA_WIDTH-1:0] res_out,
    output logic [DATA_WIDTH-1:0] dvs_out,
    output logic [DATA_WIDTH-1:0] dvd_out,
    output logic [DATA_WIDTH-1:0] rem_out,
    output logic [DATA_WIDTH-1:0] quo_out
);
    localparam int W = DATA_WIDTH;

    kvia_pkg::ctl_t ctl_reg;
    logic [W-1:0]   res_reg, dvs_reg, dvd_reg, rem_reg, quo_reg;
    logic [W:0]     trial, diff;
    logic           fits;

    // Trial subtraction of the divisor.
    always_comb
    begin
        trial = {rem_in, dvd_in[W-1]};
        diff  = trial - {1'b0, dvs_in};
        fits  = !diff[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_in;
        dvs_reg <= dvs_in;
        dvd_reg <= dvd_in << 1;
        rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        quo_reg <= {quo_in[W-2:0], fits};
    end

    assign ctl_out = ctl_reg;
    assign res_out = res_reg;
    assign dvs_out = dvs_reg;
    assign dvd_out = dvd_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

@@ rtl/known_value_integer_alu.sv @@
// ---------------------------------------------------------------------------
// known_value_integer_alu: integer ALU with known-value propagation
// Front end, a row of DATA_WIDTH division cells and a result register.
// ---------------------------------------------------------------------------
// Throughput: one operation per cycle; busy stays low.
// Every operation travels the full row of DATA_WIDTH division cells,
// one quotient bit per cell.
// Reset clears all valid bits; the receiver cannot stall.
module known_value_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         opcode,
    input  logic signed [63:0] left_value,
    input  logic               left_known,
    input  logic signed [63:0] right_value,
    input  logic               right_known,
    output logic               done,
    output logic signed [63:0] result_value,
    output logic               result_known
);
    localparam int W   = DATA_WIDTH;
    localparam int LAT = DATA_WIDTH + 3;

    kvia_pkg::ctl_t ctl_c [0:W];
    logic [W-1:0]   res_c [0:W];
    logic [W-1:0]   dvs_c [0:W];
    logic [W-1:0]   dvd_c [0:W];
    logic [W-1:0]   rem_c [0:W];
    logic [W-1:0]   quo_c [0:W];

    logic [W-1:0]   val;
    logic           done_reg, known_reg;
    logic [63:0]    value_reg;

    assign busy = 1'b0;

    kvia_prep #(.DATA_WIDTH(W)) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .left_value  (left_value),
        .left_known  (left_known),
        .right_value (right_value),
        .right_known (right_known),
        .ctl         (ctl_c[0]),
        .res         (res_c[0]),
        .mag_a       (dvd_c[0]),
        .mag_b       (dvs_c[0])
    );

    assign rem_c[0] = '0;
    assign quo_c[0] = '0;

    // Row of division cells.
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        kvia_cell #(.DATA_WIDTH(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_c[i]),
            .res_in  (res_c[i]),
            .dvs_in  (dvs_c[i]),
            .dvd_in  (dvd_c[i]),
            .rem_in  (rem_c[i]),
            .quo_in  (quo_c[i]),
            .ctl_out (ctl_c[i+1]),
            .res_out (res_c[i+1]),
            .dvs_out (dvs_c[i+1]),
            .dvd_out (dvd_c[i+1]),
            .rem_out (rem_c[i+1]),
            .quo_out (quo_c[i+1])
        );
    end

    // Sign fix of quotient and remainder, then result select.
    always_comb
    begin
        if (ctl_c[W].is_div)
        begin
            val = ctl_c[W].neg_q ? ('0 - quo_c[W]) : quo_c[W];
        end
        else if (ctl_c[W].is_mod)
        begin
            val = ctl_c[W].neg_r ? ('0 - rem_c[W]) : rem_c[W];
        end
        else
        begin
            val = res_c[W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_c[W].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        known_reg <= ctl_c[W].known;
        value_reg <= ctl_c[W].known ? 64'($signed(val)) : 64'd0;
    end

    assign done         = done_reg;
    assign result_known = known_reg;
    assign result_value = value_reg;

    // An unknown result always reads as zero.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result_known |-> result_value == 64'd0)
        else $error("unknown result is not zero");

    // Every done strobe answers an earlier start transfer, and every start transfer gets one.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, LAT) |-> done == $past(start && !busy, LAT))
        else $error("done strobe out of step with start");

    // The ALU never refuses an operation.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

@@ verif/known_value_integer_alu_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// known_value_integer_alu_test: self-checking bench of the known-value ALU
// Directed corner operations and random operations are sent with random
// gaps; each done strobe is checked against a computed expected result.
// ---------------------------------------------------------------------------
module known_value_integer_alu_test;

    localparam int LATENCY     = 67;
    localparam int STALL_LIMIT = 2000;
    localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_VAL = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONE = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        logic [63:0] value;
        logic        known;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [4:0]  opcode;
    logic signed [63:0] left_value;
    logic        left_known;
    logic signed [63:0] right_value;
    logic        right_known;
    logic        done;
    logic signed [63:0] result_value;
    logic        result_known;

    outcome_t    pending_results[$];
    int          error_count;
    int          quiet_cycles;

    known_value_integer_alu uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .left_value(left_value), .left_known(left_known),
        .right_value(right_value), .right_known(right_known),
        .done(done), .result_value(result_value), .result_known(result_known)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Compute the ALU outcome of one operation.
    function automatic outcome_t alu_outcome(logic [4:0] op, logic [63:0] a, logic ak,
                                             logic [63:0] b, logic bk);
        outcome_t res;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        sa = a;
        sb = b;
        r = '0;
        res.known = (op >= kvia_pkg::OP_NEG && op <= kvia_pkg::OP_NOT) ? ak : (ak && bk);
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        case (op)
            kvia_pkg::OP_LOR:  r = {63'd0, (a != 0) || (b != 0)};
            kvia_pkg::OP_LAND: r = {63'd0, (a != 0) && (b != 0)};
            kvia_pkg::OP_OR:   r = a | b;
            kvia_pkg::OP_XOR:  r = a ^ b;
            kvia_pkg::OP_AND:  r = a & b;
            kvia_pkg::OP_EQ:   r = {63'd0, a == b};
            kvia_pkg::OP_NE:   r = {63'd0, a != b};
            kvia_pkg::OP_LT:   r = {63'd0, sa < sb};
            kvia_pkg::OP_GT:   r = {63'd0, sa > sb};
            kvia_pkg::OP_GE:   r = {63'd0, sa >= sb};
            kvia_pkg::OP_LE:   r = {63'd0, sa <= sb};
            kvia_pkg::OP_SHR, kvia_pkg::OP_SHL:
            begin
                if (b[63] || b >= 64)
                    res.known = 1'b0;
                else if (op == kvia_pkg::OP_SHL)
                    r = a << b[5:0];
                else
                    r = sa >>> b[5:0];
            end
            kvia_pkg::OP_SUB:  r = a - b;
            kvia_pkg::OP_ADD:  r = a + b;
            kvia_pkg::OP_MUL:  r = a * b;
            kvia_pkg::OP_DIV, kvia_pkg::OP_MOD:
            begin
                if (b == 0)
                    res.known = 1'b0;
                else if (op == kvia_pkg::OP_DIV)
                    r = (a[63] != b[63]) ? -(ma / mb) : (ma / mb);
                else
                    r = a[63] ? -(ma % mb) : (ma % mb);
            end
            kvia_pkg::OP_NEG:  r = -a;
            kvia_pkg::OP_LNOT: r = {63'd0, a == 0};
            kvia_pkg::OP_NOT:  r = ~a;
            default: res.known = 1'b0;
        endcase
        res.value = res.known ? r : '0;
        return res;
    endfunction

    // Send one operation after a random gap and record its outcome.
    task automatic send_op(logic [4:0] op, logic [63:0] a, logic ak, logic [63:0] b, logic bk);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        left_value  <= a;
        left_known  <= ak;
        right_value <= b;
        right_known <= bk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(alu_outcome(op, a, ak, b, bk));
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return ALL_ONE;
            3: return 64'($urandom_range(0, 70));
            4: return -64'($urandom_range(1, 70));
            5: return 64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_extremes();
        logic [63:0] corners[6];
        corners = '{MIN_VAL, MAX_VAL, ALL_ONE, 64'd0, 64'd1, 64'hAAAA_5555_AAAA_5555};
        for (int i = 0; i < 6; i++)
            send_op(kvia_pkg::OP_ADD, corners[i], 1'b1, corners[5 - i], 1'b1);
        send_op(kvia_pkg::OP_MUL, MAX_VAL, 1'b1, MAX_VAL, 1'b1);
        send_op(kvia_pkg::OP_SUB, MIN_VAL, 1'b1, 64'd1, 1'b1);
    endtask

    task automatic test_every_opcode();
        for (int op = 0; op < 32; op++)
            send_op(5'(op), 64'hFFFF_FFFF_FFFF_FFF9, 1'b1, 64'd3, 1'b1);
    endtask

    task automatic test_special_cases();
        send_op(kvia_pkg::OP_DIV, MIN_VAL, 1'b1, ALL_ONE, 1'b1);
        send_op(kvia_pkg::OP_MOD, MIN_VAL, 1'b1, ALL_ONE, 1'b1);
        send_op(kvia_pkg::OP_DIV, 64'd5, 1'b1, 64'd0, 1'b1);
        send_op(kvia_pkg::OP_MOD, 64'd5, 1'b1, 64'd0, 1'b1);
        send_op(kvia_pkg::OP_SHL, 64'd1, 1'b1, 64'd63, 1'b1);
        send_op(kvia_pkg::OP_SHL, 64'd1, 1'b1, 64'd64, 1'b1);
        send_op(kvia_pkg::OP_SHR, MIN_VAL, 1'b1, 64'd63, 1'b1);
        send_op(kvia_pkg::OP_SHR, MIN_VAL, 1'b1, ALL_ONE, 1'b1);
        send_op(kvia_pkg::OP_ADD, 64'd1, 1'b0, 64'd2, 1'b1);
        send_op(kvia_pkg::OP_SUB, 64'd1, 1'b1, 64'd2, 1'b0);
        send_op(kvia_pkg::OP_NEG, 64'd9, 1'b1, 64'd2, 1'b0);
        send_op(kvia_pkg::OP_NOT, 64'd9, 1'b0, 64'd2, 1'b1);
    endtask

    task automatic test_random_ops();
        logic [4:0] op;
        for (int i = 0; i < 1500; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 20));
            send_op(op, pick_operand(), $urandom_range(0, 9) != 0,
                    pick_operand(), $urandom_range(0, 9) != 0);
        end
    endtask

    // Check every done strobe against the oldest pending outcome.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    $error("result_value expected %h actual %h", want.value, result_value);
                    error_count++;
                end
                if (result_known !== want.known)
                begin
                    $error("result_known expected %b actual %b", want.known, result_known);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL known_value_integer_alu");
            $finish;
        end
    end

    // Reset, run each test, drain and report.
    initial
    begin
        error_count  = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        left_value   = '0;
        left_known   = 1'b0;
        right_value  = '0;
        right_known  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_every_opcode();
        test_special_cases();
        test_random_ops();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("PASS known_value_integer_alu");
        else
            $display("FAIL known_value_integer_alu");
        $finish;
    end

endmodule
